FILE: rtl/fsts_pkg.sv
// ----------------------------------------------------------------------------
// fsts_pkg
// shared types, codes and constants of the fair share thread scheduler
// ----------------------------------------------------------------------------
package fsts_pkg;

    localparam int DEF_MAX_THREADS = 64;
    localparam int DEF_PRIO_LEVELS = 8;

    localparam int VT_W   = 48;
    localparam int TID_W  = 6;
    localparam int PRIO_W = 3;
    localparam int WGT_W  = 4;
    localparam int CFG_W  = 32;

    localparam logic [CFG_W-1:0] RST_GRAN  = 32'd5000000;
    localparam logic [CFG_W-1:0] RST_EPOCH = 32'd50000000;

    localparam logic [0:0] REG_GRAN  = 1'b0;
    localparam logic [0:0] REG_EPOCH = 1'b1;

    typedef enum logic [1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_SUSPEND = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_REFUSED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHARGE,
        ST_CHECK,
        ST_SCAN,
        ST_POP,
        ST_EPOCH,
        ST_SLICE,
        ST_INSERT,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/fsts_div.sv
// ----------------------------------------------------------------------------
// fsts_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fsts_div #(
    parameter int NW = 48,
    parameter int DW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DW:0]      rem_sh;
    logic             take;

    assign rem_sh   = {rem_reg, quo_reg[NW-1]};
    assign take     = rem_sh >= {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= take ? DW'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], take};
        end
    end

endmodule

FILE: rtl/fair_share_thread_scheduler.sv
// ----------------------------------------------------------------------------
// fair_share_thread_scheduler
// virtual-runtime fair scheduler with a ready table and one shared divider
// ----------------------------------------------------------------------------
// a request is taken at a clock edge with start high and busy low; kind selects
// enqueue, timer tick or suspend of the running thread. busy stays high until
// the single result, shown for one cycle with done high. the receiver cannot
// stall, so the result must be taken in that cycle.
// min_granularity and default_epoch are written through cfg_we, cfg_index and
// cfg_wdata, by the user only while the block is idle; the block does not enforce it.
// a tick charges the running thread through the divider, whose width NW is
// 48 by default; a switch adds a scan of the ready table, one entry per
// cycle, and a second divide for the new slice. the next request is taken
// the cycle after done. the bit-serial divider and the one-port table scan
// set how long a request takes.
// reset makes thread 0 the running thread with an empty ready table and loads
// the default granularity and epoch.
// ----------------------------------------------------------------------------
module fair_share_thread_scheduler #(
    parameter int MAX_THREADS     = fsts_pkg::DEF_MAX_THREADS,
    parameter int PRIORITY_LEVELS = fsts_pkg::DEF_PRIO_LEVELS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [fsts_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   kind,
    input  logic [fsts_pkg::TID_W-1:0]   thread_id,
    input  logic [fsts_pkg::PRIO_W-1:0]  priority_req,
    input  logic [fsts_pkg::VT_W-1:0]    vruntime,
    input  logic                         was_suspended,
    input  logic [fsts_pkg::VT_W-1:0]    now,
    output logic                         done,
    output logic [1:0]                   status,
    output logic                         switched,
    output logic [fsts_pkg::TID_W-1:0]   next_thread,
    output logic [fsts_pkg::TID_W-1:0]   prev_thread,
    output logic [fsts_pkg::VT_W-1:0]    prev_vruntime,
    output logic [fsts_pkg::VT_W-1:0]    slice_length
);

    localparam int VT_W   = fsts_pkg::VT_W;
    localparam int TID_W  = fsts_pkg::TID_W;
    localparam int PRIO_W = fsts_pkg::PRIO_W;
    localparam int WGT_W  = fsts_pkg::WGT_W;
    localparam int CFG_W  = fsts_pkg::CFG_W;
    localparam int IW     = $clog2(MAX_THREADS);
    localparam int CW     = $clog2(MAX_THREADS + 1);
    localparam int WTW    = $clog2(MAX_THREADS * 8 + 1);
    localparam int EPW    = CW + CFG_W;
    localparam int PRW    = EPW + WGT_W;
    localparam int NW     = (PRW > VT_W) ? PRW : VT_W;
    localparam int MW     = TID_W + VT_W + PRIO_W;

    fsts_pkg::state_t state_reg, state_next;

    logic [MAX_THREADS-1:0] valid_reg;
    logic [MW-1:0]          mem [MAX_THREADS];
    logic [MW-1:0]          rd_data_reg;
    logic [IW-1:0]          rd_idx_reg;
    logic                   rd_pend_reg;
    logic [CW-1:0]          scan_idx_reg;

    logic [CW-1:0]          entries_reg;
    logic [WTW-1:0]         weight_reg;
    logic [VT_W-1:0]        floor_reg;
    logic [TID_W-1:0]       run_thread_reg;
    logic [VT_W-1:0]        run_vtime_reg;
    logic [PRIO_W-1:0]      run_prio_reg;
    logic [VT_W-1:0]        slice_start_reg;
    logic [VT_W-1:0]        last_tick_reg;
    logic [VT_W-1:0]        slice_len_reg;
    logic [CFG_W-1:0]       gran_reg;
    logic [CFG_W-1:0]       epoch_reg;

    logic [1:0]             kind_reg;
    logic [VT_W-1:0]        now_reg;
    logic [TID_W-1:0]       ins_thread_reg;
    logic [VT_W-1:0]        ins_vt_reg;
    logic [PRIO_W-1:0]      ins_prio_reg;
    logic                   ins_susp_reg;
    logic                   reins_reg;
    logic [1:0]             status_reg;
    logic                   switched_reg;
    logic [TID_W-1:0]       prev_reg;
    logic [VT_W-1:0]        prev_vt_reg;

    logic                   found_reg;
    logic [IW-1:0]          best_idx_reg;
    logic [TID_W-1:0]       best_thread_reg;
    logic [VT_W-1:0]        best_vt_reg;
    logic [PRIO_W-1:0]      best_prio_reg;
    logic [EPW-1:0]         prod_reg;

    logic                   accept;
    logic [PRIO_W-1:0]      prio_clamped;
    logic [IW-1:0]          free_idx;
    logic [VT_W-1:0]        served;
    logic                   due;
    logic [EPW-1:0]         epoch_sel;
    logic [WGT_W-1:0]       run_wgt;
    logic                   div_start;
    logic [NW-1:0]          div_dividend;
    logic [WTW-1:0]         div_divisor;
    logic                   div_done;
    logic [NW-1:0]          div_quo;
    logic [VT_W-1:0]        rd_vt;
    logic [VT_W-1:0]        ins_vt_adj;

    assign accept       = start && !busy;
    assign prio_clamped = ({4'b0, priority_req} > 7'(PRIORITY_LEVELS - 1)) ?
                          PRIO_W'(PRIORITY_LEVELS - 1) : priority_req;
    assign served       = now_reg - slice_start_reg;
    assign due          = (served >= slice_len_reg) && (served >= VT_W'(gran_reg)) &&
                          (entries_reg != '0);
    assign epoch_sel    = ({{CW{1'b0}}, epoch_reg} >= prod_reg) ?
                          {{CW{1'b0}}, epoch_reg} : prod_reg;
    assign run_wgt      = {1'b0, run_prio_reg} + 1'b1;
    assign rd_vt        = rd_data_reg[PRIO_W +: VT_W];
    assign ins_vt_adj   = (ins_susp_reg || ins_vt_reg == '0) ? ins_vt_reg + floor_reg :
                          ins_vt_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = MAX_THREADS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = NW'(now - last_tick_reg);
        div_divisor  = WTW'(run_wgt);
        if (accept && kind == fsts_pkg::KIND_TICK)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == fsts_pkg::ST_EPOCH)
        begin
            div_start    = 1'b1;
            div_dividend = NW'(epoch_sel) * NW'(run_wgt);
            div_divisor  = weight_reg + WTW'(run_wgt);
        end
    end

    fsts_div #(
        .NW (NW),
        .DW (WTW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fsts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        fsts_pkg::KIND_ENQUEUE:
                            state_next = (entries_reg >= CW'(MAX_THREADS)) ?
                                         fsts_pkg::ST_DONE : fsts_pkg::ST_INSERT;
                        fsts_pkg::KIND_TICK:
                            state_next = fsts_pkg::ST_CHARGE;
                        fsts_pkg::KIND_SUSPEND:
                            state_next = (entries_reg == '0) ?
                                         fsts_pkg::ST_DONE : fsts_pkg::ST_SCAN;
                        default:
                            state_next = fsts_pkg::ST_DONE;
                    endcase
                end
            end
            fsts_pkg::ST_CHARGE:
                if (div_done)
                begin
                    state_next = fsts_pkg::ST_CHECK;
                end
            fsts_pkg::ST_CHECK:
                state_next = due ? fsts_pkg::ST_SCAN : fsts_pkg::ST_DONE;
            fsts_pkg::ST_SCAN:
                if (scan_idx_reg == CW'(MAX_THREADS) && !rd_pend_reg)
                begin
                    state_next = fsts_pkg::ST_POP;
                end
            fsts_pkg::ST_POP:
                state_next = fsts_pkg::ST_EPOCH;
            fsts_pkg::ST_EPOCH:
                state_next = fsts_pkg::ST_SLICE;
            fsts_pkg::ST_SLICE:
                if (div_done)
                begin
                    state_next = reins_reg ? fsts_pkg::ST_INSERT : fsts_pkg::ST_DONE;
                end
            fsts_pkg::ST_INSERT:
                state_next = fsts_pkg::ST_DONE;
            fsts_pkg::ST_DONE:
                state_next = fsts_pkg::ST_IDLE;
            default:
                state_next = fsts_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy          = (state_reg != fsts_pkg::ST_IDLE);
        done          = (state_reg == fsts_pkg::ST_DONE);
        status        = status_reg;
        switched      = switched_reg;
        next_thread   = run_thread_reg;
        prev_thread   = prev_reg;
        prev_vruntime = prev_vt_reg;
        slice_length  = slice_len_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ready table storage
    always_ff @(posedge clk)
    begin
        if (state_reg == fsts_pkg::ST_INSERT)
        begin
            mem[free_idx] <= {ins_thread_reg, ins_vt_adj, ins_prio_reg};
        end
        rd_data_reg <= mem[scan_idx_reg[IW-1:0]];
    end

    // scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            entries_reg     <= '0;
            weight_reg      <= '0;
            floor_reg       <= '0;
            run_thread_reg  <= '0;
            run_vtime_reg   <= '0;
            run_prio_reg    <= '0;
            slice_start_reg <= '0;
            last_tick_reg   <= '0;
            slice_len_reg   <= '0;
            gran_reg        <= fsts_pkg::RST_GRAN;
            epoch_reg       <= fsts_pkg::RST_EPOCH;
            rd_pend_reg     <= 1'b0;
            scan_idx_reg    <= '0;
            found_reg       <= 1'b0;
            reins_reg       <= 1'b0;
            status_reg      <= fsts_pkg::STAT_OK;
            switched_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fsts_pkg::REG_GRAN:  gran_reg  <= cfg_wdata;
                    fsts_pkg::REG_EPOCH: epoch_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            case (state_reg)
                fsts_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        switched_reg <= 1'b0;
                        reins_reg    <= 1'b0;
                        scan_idx_reg <= '0;
                        rd_pend_reg  <= 1'b0;
                        found_reg    <= 1'b0;
                        if (kind == fsts_pkg::KIND_ENQUEUE &&
                            entries_reg >= CW'(MAX_THREADS))
                        begin
                            status_reg <= fsts_pkg::STAT_FULL;
                        end
                        else if (kind == fsts_pkg::KIND_SUSPEND && entries_reg == '0)
                        begin
                            status_reg <= fsts_pkg::STAT_REFUSED;
                        end
                        else
                        begin
                            status_reg <= fsts_pkg::STAT_OK;
                        end
                    end
                end
                fsts_pkg::ST_CHARGE:
                begin
                    if (div_done)
                    begin
                        run_vtime_reg <= run_vtime_reg + div_quo[VT_W-1:0];
                        last_tick_reg <= now_reg;
                    end
                end
                fsts_pkg::ST_CHECK:
                begin
                    reins_reg <= due;
                end
                fsts_pkg::ST_SCAN:
                begin
                    if (scan_idx_reg != CW'(MAX_THREADS))
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        rd_pend_reg  <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                    if (rd_pend_reg && valid_reg[rd_idx_reg] &&
                        (!found_reg || rd_vt < best_vt_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                end
                fsts_pkg::ST_POP:
                begin
                    valid_reg[best_idx_reg] <= 1'b0;
                    entries_reg    <= entries_reg - 1'b1;
                    weight_reg     <= weight_reg - WTW'({1'b0, best_prio_reg} + 1'b1);
                    run_thread_reg <= best_thread_reg;
                    run_vtime_reg  <= best_vt_reg;
                    run_prio_reg   <= best_prio_reg;
                    floor_reg      <= best_vt_reg;
                    switched_reg   <= 1'b1;
                end
                fsts_pkg::ST_SLICE:
                begin
                    if (div_done)
                    begin
                        slice_len_reg   <= div_quo[VT_W-1:0];
                        slice_start_reg <= now_reg;
                    end
                end
                fsts_pkg::ST_INSERT:
                begin
                    valid_reg[free_idx] <= 1'b1;
                    entries_reg <= entries_reg + 1'b1;
                    weight_reg  <= weight_reg + WTW'({1'b0, ins_prio_reg} + 1'b1);
                end
                default: ;
            endcase
        end
    end

    // request and scan payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_idx_reg[IW-1:0];
        if (accept)
        begin
            kind_reg       <= kind;
            now_reg        <= now;
            ins_thread_reg <= thread_id;
            ins_vt_reg     <= vruntime;
            ins_prio_reg   <= prio_clamped;
            ins_susp_reg   <= was_suspended;
            prev_reg       <= run_thread_reg;
            prev_vt_reg    <= (kind == fsts_pkg::KIND_SUSPEND && entries_reg != '0) ?
                              run_vtime_reg - floor_reg : run_vtime_reg;
        end
        if (state_reg == fsts_pkg::ST_CHARGE && div_done)
        begin
            prev_vt_reg <= run_vtime_reg + div_quo[VT_W-1:0];
        end
        if (state_reg == fsts_pkg::ST_CHECK)
        begin
            ins_thread_reg <= run_thread_reg;
            ins_vt_reg     <= run_vtime_reg;
            ins_prio_reg   <= run_prio_reg;
            ins_susp_reg   <= 1'b0;
        end
        if (state_reg == fsts_pkg::ST_SCAN && rd_pend_reg && valid_reg[rd_idx_reg] &&
            (!found_reg || rd_vt < best_vt_reg))
        begin
            best_idx_reg    <= rd_idx_reg;
            best_thread_reg <= rd_data_reg[PRIO_W + VT_W +: TID_W];
            best_vt_reg     <= rd_vt;
            best_prio_reg   <= rd_data_reg[PRIO_W-1:0];
        end
        if (state_reg == fsts_pkg::ST_POP)
        begin
            prod_reg <= EPW'(entries_reg) * EPW'(gran_reg);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("result not followed by idle");

    assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy)
        else $error("request accepted without going busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        entries_reg == CW'($countones(valid_reg)))
        else $error("ready count differs from valid entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && switched |-> status == fsts_pkg::STAT_OK)
        else $error("switch reported with error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && kind_reg == fsts_pkg::KIND_ENQUEUE |-> !switched)
        else $error("enqueue caused a switch");

endmodule
